// File: design/vn2d_pkg.sv
package vn2d_pkg;

  // Fraction bits of the input coordinates (legal range 8 to 24).
  localparam int unsigned CoordFracBits = 16;

  localparam int unsigned StageCnt = 10;

  localparam logic [31:0] HashMulX  = 32'h9e37_79b9;
  localparam logic [31:0] HashMulZ  = 32'h85eb_ca6b;
  localparam logic [31:0] MixMulA   = 32'h7feb_352d;
  localparam logic [31:0] MixMulB   = 32'h846c_a68b;

  localparam int unsigned FracShR = (CoordFracBits >= 16) ? CoordFracBits - 16 : 0;
  localparam int unsigned FracShL = (CoordFracBits < 16) ? 16 - CoordFracBits : 0;
  localparam logic [31:0] FracMask = 32'((64'd1 << CoordFracBits) - 64'd1);

  typedef logic signed [16:0] lattice_t;
  typedef logic [3:0][31:0]   hash4_t;

  function automatic logic [31:0] xs16(logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

  function automatic logic [31:0] xs15(logic [31:0] v);
    return v ^ (v >> 15);
  endfunction

  // Integer cell corner: arithmetic shift keeps the sign of the coordinate.
  function automatic logic [31:0] cell_of(logic [31:0] c);
    return 32'($signed(c) >>> CoordFracBits);
  endfunction

  // Cell fraction scaled to 16 bits, truncating extra fraction bits.
  function automatic logic [15:0] frac16(logic [31:0] c);
    logic [31:0] f;
    f = c & FracMask;
    return 16'((f >> FracShR) << FracShL);
  endfunction

  // Lattice value (hash >> 15) - 65536 as a signed 17-bit number.
  function automatic lattice_t lattice_of(logic [31:0] h);
    return lattice_t'({~h[31], h[30:15]});
  endfunction

endpackage

// File: design/value_noise_2d.sv
// Two-dimensional value noise. Each input transaction carries one point (x, z) in
// signed fixed point and produces exactly one output transaction with the noise
// value in signed Q1.16. The datapath is a ten-stage pipeline: one point enters
// every clock while the output side keeps up. Throughput is one item per cycle
// then; the 32-bit multipliers of the hash mixers sit in stages two to five. A
// stall on the output holds only the full stages with no empty stage after them;
// the others move on into the gaps, so the input stays ready until the pipeline
// is completely full. The seed enters the corner mix in stage four, so a write
// also reaches points not yet past it; write it only while the pipeline is empty.
module value_noise_2d
  import vn2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,     // noise_seed
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] coord_x, [63:32] coord_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [16:0] noise_value, [23:17] zero
);

  logic [31:0]         seed_q;
  logic [StageCnt-1:0] vld_q;
  logic [StageCnt-1:0] adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_data_i;
    end
  end

  // A stage may load when it is empty or when its content moves on.
  always_comb begin
    adv[StageCnt-1] = !vld_q[StageCnt-1] || m_axis_tready;
    for (int i = StageCnt - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < StageCnt; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Stage 1: cell corners times the axis constants, fraction and its square.
  logic [31:0] hx1_q, hz1_q, ttx1_q, ttz1_q;
  logic [15:0] tx1_q, tz1_q;
  // Stage 2: first mixer multiply, smootherstep t^3 and polynomial k.
  hash4_t      p2_q;
  logic [31:0] t3x2_q, t3z2_q;
  logic [19:0] kx2_q, kz2_q;
  // Stage 3: second mixer multiply, raw eased fraction.
  hash4_t      q3_q;
  logic [35:0] srx3_q, srz3_q;
  // Stage 4/5: corner mix with seed.
  hash4_t      r4_q, r5_q;
  logic [16:0] sx4_q, sz4_q, sx5_q, sz5_q, sx6_q, sz6_q, sz7_q, sz8_q;
  // Stage 6 onward: interpolation.
  lattice_t    an6_q, as6_q, an7_q, as7_q, north8_q, north9_q, res10_q;
  logic signed [17:0] dn6_q, ds6_q, dz8_q;
  logic signed [35:0] pn7_q, ps7_q, pz9_q;

  logic [31:0] cx_in, cz_in;
  logic [15:0] tx_in, tz_in;
  hash4_t      a2, m4;
  logic [31:0] c4 [4];
  lattice_t    lat6 [4];
  logic [18:0] n8, s8, r10;
  logic [34:0] six_x, six_z;
  logic [19:0] trx, trz;

  always_comb begin
    cx_in = s_axis_tdata[31:0];
    cz_in = s_axis_tdata[63:32];
    tx_in = frac16(cx_in);
    tz_in = frac16(cz_in);

    // The corner plus one times C equals the corner product plus C.
    a2[0] = hx1_q;
    a2[1] = hx1_q + HashMulX;
    a2[2] = hz1_q;
    a2[3] = hz1_q + HashMulZ;
    six_x = 35'(ttx1_q) * 35'd6;
    six_z = 35'(ttz1_q) * 35'd6;

    trx = srx3_q[35:16];
    trz = srz3_q[35:16];

    for (int i = 0; i < 4; i++) begin
      m4[i] = xs16(q3_q[i]);
    end
    c4[0] = seed_q ^ m4[0] ^ m4[2];
    c4[1] = seed_q ^ m4[1] ^ m4[2];
    c4[2] = seed_q ^ m4[0] ^ m4[3];
    c4[3] = seed_q ^ m4[1] ^ m4[3];

    for (int i = 0; i < 4; i++) begin
      lat6[i] = lattice_of(xs16(r5_q[i]));
    end

    n8  = 19'(an7_q) + 19'(pn7_q >>> 16);
    s8  = 19'(as7_q) + 19'(ps7_q >>> 16);
    r10 = 19'(north9_q) + 19'(pz9_q >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      hx1_q  <= cell_of(cx_in) * HashMulX;
      hz1_q  <= cell_of(cz_in) * HashMulZ;
      tx1_q  <= tx_in;
      tz1_q  <= tz_in;
      ttx1_q <= 32'(tx_in) * 32'(tx_in);
      ttz1_q <= 32'(tz_in) * 32'(tz_in);
    end
    if (adv[1]) begin
      for (int i = 0; i < 4; i++) begin
        p2_q[i] <= xs16(a2[i]) * MixMulA;
      end
      t3x2_q <= 32'(ttx1_q[31:16]) * 32'(tx1_q);
      t3z2_q <= 32'(ttz1_q[31:16]) * 32'(tz1_q);
      kx2_q  <= 20'd655360 - 20'(20'(tx1_q) * 20'd15) + six_x[34:16];
      kz2_q  <= 20'd655360 - 20'(20'(tz1_q) * 20'd15) + six_z[34:16];
    end
    if (adv[2]) begin
      for (int i = 0; i < 4; i++) begin
        q3_q[i] <= xs15(p2_q[i]) * MixMulB;
      end
      srx3_q <= 36'(t3x2_q[31:16]) * 36'(kx2_q);
      srz3_q <= 36'(t3z2_q[31:16]) * 36'(kz2_q);
    end
    if (adv[3]) begin
      for (int i = 0; i < 4; i++) begin
        r4_q[i] <= xs16(c4[i]) * MixMulA;
      end
      sx4_q <= (trx > 20'd65536) ? 17'd65536 : trx[16:0];
      sz4_q <= (trz > 20'd65536) ? 17'd65536 : trz[16:0];
    end
    if (adv[4]) begin
      for (int i = 0; i < 4; i++) begin
        r5_q[i] <= xs15(r4_q[i]) * MixMulB;
      end
      sx5_q <= sx4_q;
      sz5_q <= sz4_q;
    end
    if (adv[5]) begin
      an6_q <= lat6[0];
      dn6_q <= 18'(lat6[1]) - 18'(lat6[0]);
      as6_q <= lat6[2];
      ds6_q <= 18'(lat6[3]) - 18'(lat6[2]);
      sx6_q <= sx5_q;
      sz6_q <= sz5_q;
    end
    if (adv[6]) begin
      an7_q <= an6_q;
      as7_q <= as6_q;
      pn7_q <= 36'(dn6_q) * $signed(36'(sx6_q));
      ps7_q <= 36'(ds6_q) * $signed(36'(sx6_q));
      sz7_q <= sz6_q;
    end
    if (adv[7]) begin
      north8_q <= lattice_t'(n8[16:0]);
      // The upper sums carry the sign, so the difference keeps it.
      dz8_q    <= 18'(s8) - 18'(n8);
      sz8_q    <= sz7_q;
    end
    if (adv[8]) begin
      north9_q <= north8_q;
      pz9_q    <= 36'(dz8_q) * $signed(36'(sz8_q));
    end
    if (adv[9]) begin
      res10_q <= lattice_t'(r10[16:0]);
    end
  end

  assign m_axis_tvalid = vld_q[StageCnt-1];
  assign m_axis_tdata  = {7'd0, res10_q};

  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&vld_q) |-> s_axis_tready)
    else $error("input not ready although the pipeline has an empty stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted transaction did not enter the first stage");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[StageCnt-1] && !m_axis_tready) |=> (vld_q[StageCnt-1] && $stable(res10_q)))
    else $error("stalled result changed or vanished");

  a_seed_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (seed_q == $past(cfg_data_i)))
    else $error("seed register did not take the written value");

endmodule

// File: dv/value_noise_2d_checker.sv
module value_noise_2d_checker
  import vn2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,     // noise_seed
  input  logic        pt_valid_i,
  input  logic        pt_ready_i,
  input  logic [63:0] pt_data_i,      // [31:0] coord_x, [63:32] coord_z
  input  logic        nv_valid_i,
  input  logic        nv_ready_i,
  input  logic [23:0] nv_data_i,      // [16:0] noise_value, [23:17] zero
  output int unsigned mismatch_cnt_o,
  output int unsigned inflight_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] seed_q;
  logic [16:0] noise_due_q[$];

  function automatic logic [31:0] scramble(logic [31:0] v);
    logic [31:0] r;
    r = v ^ (v >> 16);
    r = r * MixMulA;
    r = r ^ (r >> 15);
    r = r * MixMulB;
    r = r ^ (r >> 16);
    return r;
  endfunction

  // Signed lattice height at one integer corner, in units of 2^-16.
  function automatic longint corner_height(logic [31:0] seed, logic [31:0] ix,
                                           logic [31:0] iz);
    logic [31:0] h;
    h = scramble(seed ^ scramble(ix * HashMulX) ^ scramble(iz * HashMulZ));
    return longint'({32'd0, h >> 15}) - 64'sd65536;
  endfunction

  function automatic logic [31:0] cell_index(logic [31:0] c);
    logic signed [31:0] sc;
    sc = c;
    return sc >>> CoordFracBits;
  endfunction

  function automatic logic [63:0] frac_q16(logic [31:0] c);
    logic [63:0] mask;
    logic [31:0] f;
    mask = (64'd1 << CoordFracBits) - 64'd1;
    f = c & mask[31:0];
    if (CoordFracBits >= 16) begin
      return {32'd0, f >> (CoordFracBits - 16)};
    end
    return {48'd0, 16'(f << (16 - CoordFracBits))};
  endfunction

  // Quintic easing 6t^5 - 15t^4 + 10t^3 in Q0.16, clamped to 1.0.
  function automatic longint smootherstep(logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] k;
    logic [63:0] s;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    k = ((64'd10 << 32) - ((64'd15 * t) << 16) + 64'd6 * t * t) >> 16;
    s = (t3 * k) >> 16;
    if (s > 64'd65536) begin
      s = 64'd65536;
    end
    return longint'(s);
  endfunction

  // The arithmetic shift floors, so the blend never leaves [a, b].
  function automatic longint blend(longint a, longint b, longint s);
    longint d;
    d = (b - a) * s;
    return a + (d >>> 16);
  endfunction

  function automatic logic [16:0] noise_at(logic [31:0] seed, logic [31:0] x,
                                           logic [31:0] z);
    logic [31:0] ix;
    logic [31:0] iz;
    logic [31:0] ix_next;
    logic [31:0] iz_next;
    longint sx;
    longint sz;
    longint north;
    longint south;
    longint r;
    ix = cell_index(x);
    iz = cell_index(z);
    ix_next = ix + 32'd1;
    iz_next = iz + 32'd1;
    sx = smootherstep(frac_q16(x));
    sz = smootherstep(frac_q16(z));
    north = blend(corner_height(seed, ix, iz), corner_height(seed, ix_next, iz), sx);
    south = blend(corner_height(seed, ix, iz_next),
                  corner_height(seed, ix_next, iz_next), sx);
    r = blend(north, south, sz);
    return 17'(r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int unsigned bad;
    logic [16:0] want;
    bad = 0;
    if (!rst_ni) begin
      seed_q <= '0;
      noise_due_q.delete();
      mismatch_cnt_o <= 0;
      inflight_o <= 0;
    end else begin
      // Retire the output first so a point accepted on this edge is never
      // matched against a result leaving on the same edge.
      if (nv_valid_i && nv_ready_i) begin
        if (noise_due_q.size() == 0) begin
          $error("noise_value: no transaction expected, got %0d",
                 $signed(nv_data_i[16:0]));
          bad++;
        end else begin
          want = noise_due_q.pop_front();
          if (nv_data_i[16:0] !== want) begin
            $error("noise_value: expected %0d, got %0d", $signed(want),
                   $signed(nv_data_i[16:0]));
            bad++;
          end
        end
      end
      if (pt_valid_i && pt_ready_i) begin
        noise_due_q = {noise_due_q, noise_at(seed_q, pt_data_i[31:0], pt_data_i[63:32])};
      end
      if (cfg_valid_i && cfg_ready_i) begin
        seed_q <= cfg_data_i;
      end
      mismatch_cnt_o <= mismatch_cnt_o + bad;
      inflight_o <= noise_due_q.size();
    end
  end

endmodule

// File: dv/value_noise_2d_tb.sv
module value_noise_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vn2d_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned SettleCycles = 2 * StageCnt;
  localparam int unsigned PhaseItems = 160;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  int unsigned mismatch_cnt;
  int unsigned inflight;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  value_noise_2d dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  value_noise_2d_checker noise_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .pt_valid_i    (s_axis_tvalid),
    .pt_ready_i    (s_axis_tready),
    .pt_data_i     (s_axis_tdata),
    .nv_valid_i    (m_axis_tvalid),
    .nv_ready_i    (m_axis_tready),
    .nv_data_i     (m_axis_tdata),
    .mismatch_cnt_o(mismatch_cnt),
    .inflight_o    (inflight)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // A point mostly anywhere, sometimes near the origin, sometimes right at
  // the edges of a cell.
  function automatic logic [31:0] pick_coord();
    logic [31:0] c;
    case ($urandom_range(0, 3))
      0, 1: c = $urandom();
      2: c = $urandom_range(0, 32'h000a_0000) - 32'h0005_0000;
      default: c = {16'($urandom()), ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000};
    endcase
    return c;
  endfunction

  task automatic send_point(input logic [31:0] x, input logic [31:0] z);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Wait until every result is back and the pipeline has emptied.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (inflight != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  logic [31:0] corner_x[12] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                32'hffff_ffff, 32'hffff_0000, 32'h0000_ffff, 32'h0000_8000,
                                32'h0001_0000, 32'h7fff_0000, 32'h1234_5678, 32'hffff_ffff};
  logic [31:0] corner_z[12] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                32'hffff_ffff, 32'hffff_0000, 32'h0000_ffff, 32'hffff_8000,
                                32'hfffe_ffff, 32'h0000_0001, 32'h8765_4321, 32'h0000_0000};

  initial begin
    logic [31:0] seeds[4];
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    seeds = '{32'hffff_ffff, $urandom(), 32'h0000_0000, $urandom()};
    idle_plan = '{0, 84, 0, 36};
    stall_plan = '{0, 0, 84, 36};
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Cell corners, extreme coordinates and the wrap of the last cell,
    // with the seed still at its reset value.
    foreach (corner_x[i]) begin
      send_point(corner_x[i], corner_z[i]);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_seed(seeds[ph]);
      send_idle_pct = idle_plan[ph];
      recv_stall_pct <= stall_plan[ph];
      repeat (PhaseItems) send_point(pick_coord(), pick_coord());
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
